// ===== hdl/heading_from_displacement_defines.svh =====
// Assertion macros shared by the heading block.
`ifndef HEADING_FROM_DISPLACEMENT_DEFINES_SVH
`define HEADING_FROM_DISPLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define HFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define HFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hfd_pkg.sv =====
`timescale 1ns / 1ps

package hfd_pkg;

  localparam int SLOT_COUNT_DEF   = 256;
  localparam int COORD_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int SLOT_W   = 8;
  localparam int FIELD_W  = 16;
  localparam int HEAD_W   = 15;
  localparam int ATAN_LEN = 24;
  localparam int ATAN_W   = 20;
  localparam int PRESCALE = 24;
  localparam int Z_W      = 23;
  localparam int Z_MAX    = 90 * 16384;

  localparam logic [HEAD_W-1:0] DEG_0   = 15'd0;
  localparam logic [HEAD_W-1:0] DEG_90  = 15'd5760;
  localparam logic [HEAD_W-1:0] DEG_180 = 15'd11520;
  localparam logic [HEAD_W-1:0] DEG_270 = 15'd17280;
  localparam logic [HEAD_W-1:0] DEG_360 = 15'd23040;

  typedef struct packed {
    logic [SLOT_W-1:0]         slot;
    logic signed [FIELD_W-1:0] x_coord;
    logic signed [FIELD_W-1:0] y_coord;
  } in_t;

  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic              new_slot;
    logic              unmoved;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ITER,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic simple;
    logic last_step;
    logic out_free;
  } sts_t;

  // atan(2^-i) in 1/16384 degree, rounded
  function automatic logic [ATAN_W-1:0] atan_fine(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 20'd737280;
      5'd1:    v = 20'd435242;
      5'd2:    v = 20'd229970;
      5'd3:    v = 20'd116736;
      5'd4:    v = 20'd58595;
      5'd5:    v = 20'd29326;
      5'd6:    v = 20'd14667;
      5'd7:    v = 20'd7334;
      5'd8:    v = 20'd3667;
      5'd9:    v = 20'd1833;
      5'd10:   v = 20'd917;
      5'd11:   v = 20'd458;
      5'd12:   v = 20'd229;
      5'd13:   v = 20'd115;
      5'd14:   v = 20'd57;
      5'd15:   v = 20'd29;
      5'd16:   v = 20'd14;
      5'd17:   v = 20'd7;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      5'd20:   v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/hfd_ram.sv =====
`timescale 1ns / 1ps

module hfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/hfd_ctrl.sv =====
`timescale 1ns / 1ps

module hfd_ctrl
  import hfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

`include "heading_from_displacement_defines.svh"

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = sts_i.simple ? ST_DONE : ST_ITER;
      end
      ST_ITER: begin
        if (sts_i.last_step) state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the beat
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = 1'b1;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_EVAL: cmd_o.eval   = 1'b1;
      ST_ITER: cmd_o.step   = 1'b1;
      ST_DONE: cmd_o.finish = sts_i.out_free;
      default: in_stall_o   = 1'b1;
    endcase
  end

  `HFD_ASSERT_NEXT(a_capture_to_eval, cmd_o.capture, state_q == ST_EVAL, "capture not followed by eval")
  `HFD_ASSERT_NEXT(a_done_holds, (state_q == ST_DONE) && !sts_i.out_free, state_q == ST_DONE, "result dropped while output busy")
  `HFD_ASSERT_NEXT(a_iter_runs, (state_q == ST_ITER) && !sts_i.last_step, state_q == ST_ITER, "CORDIC pass cut short")

endmodule

// ===== hdl/hfd_dp.sv =====
`timescale 1ns / 1ps

module hfd_dp
  import hfd_pkg::*;
#(
  parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // only the first 256 slots can be named by an 8-bit slot field
  localparam int SLOT_DEPTH = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
  localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int STEPS      = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int CNT_W      = $clog2(STEPS);
  localparam int D_W        = COORD_BITS + 1;
  localparam int CW         = COORD_BITS + 28;
  localparam int MEM_W      = 2 * COORD_BITS + HEAD_W;

  // slot reduced modulo the slot count
  logic [SLOT_AW-1:0] slot_map [256];
  for (genvar g = 0; g < 256; g++) begin : g_slot_map
    assign slot_map[g] = SLOT_AW'(g % SLOT_DEPTH);
  end

  logic signed [COORD_BITS-1:0] x_in, y_in;
  if (COORD_BITS <= FIELD_W) begin : g_coord_narrow
    assign x_in = in_data_i.x_coord[COORD_BITS-1:0];
    assign y_in = in_data_i.y_coord[COORD_BITS-1:0];
  end else begin : g_coord_wide
    assign x_in = {{(COORD_BITS-FIELD_W){in_data_i.x_coord[FIELD_W-1]}}, in_data_i.x_coord};
    assign y_in = {{(COORD_BITS-FIELD_W){in_data_i.y_coord[FIELD_W-1]}}, in_data_i.y_coord};
  end

  logic [SLOT_AW-1:0] idx_in;
  assign idx_in = slot_map[in_data_i.slot];

  logic [SLOT_AW-1:0]           idx_q;
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic                         hit_q;
  logic [SLOT_DEPTH-1:0]        vld_q;

  logic [MEM_W-1:0] rd_data, wr_data;
  logic             wr_en;

  // stored point and heading of the current slot
  logic signed [COORD_BITS-1:0] lx, ly;
  logic [HEAD_W-1:0]            lh;
  assign lx = rd_data[MEM_W-1 -: COORD_BITS];
  assign ly = rd_data[MEM_W-COORD_BITS-1 -: COORD_BITS];
  assign lh = rd_data[HEAD_W-1:0];

  logic signed [D_W-1:0] dx, dy;
  logic [D_W-1:0]        abs_dx, abs_dy;
  logic                  dx_zero, dy_zero, is_new, is_same, simple;
  logic [HEAD_W-1:0]     h_simple;

  assign dx      = $signed({x_q[COORD_BITS-1], x_q}) - $signed({lx[COORD_BITS-1], lx});
  assign dy      = $signed({y_q[COORD_BITS-1], y_q}) - $signed({ly[COORD_BITS-1], ly});
  assign abs_dx  = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
  assign abs_dy  = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);
  assign is_new  = !hit_q;
  assign is_same = hit_q && dx_zero && dy_zero;
  assign simple  = is_new || dx_zero || dy_zero;

  always_comb begin
    if (is_new) begin
      h_simple = DEG_0;
    end else if (is_same) begin
      h_simple = lh;
    end else if (dy_zero) begin
      h_simple = dx[D_W-1] ? DEG_180 : DEG_0;
    end else begin
      h_simple = dy[D_W-1] ? DEG_270 : DEG_90;
    end
  end

  logic                  new_q, same_q, cordic_q, neg_x_q, neg_y_q;
  logic [HEAD_W-1:0]     h_q;
  logic signed [CW-1:0]  cx_q, cy_q;
  logic signed [Z_W-1:0] z_q;
  logic [CNT_W-1:0]      cnt_q;

  logic signed [CW-1:0] xs, ys;
  logic [ATAN_W-1:0]    atan_val;
  assign xs       = cx_q >>> cnt_q;
  assign ys       = cy_q >>> cnt_q;
  assign atan_val = atan_fine(5'(cnt_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q <= idx_in;
      x_q   <= x_in;
      y_q   <= y_in;
      hit_q <= vld_q[idx_in];
    end
    if (cmd_i.eval) begin
      new_q    <= is_new;
      same_q   <= is_same;
      cordic_q <= !simple;
      neg_x_q  <= dx[D_W-1];
      neg_y_q  <= dy[D_W-1];
      h_q      <= h_simple;
      cx_q     <= $signed(CW'(abs_dx) << PRESCALE);
      cy_q     <= $signed(CW'(abs_dy) << PRESCALE);
      z_q      <= '0;
      cnt_q    <= '0;
    end else if (cmd_i.step) begin
      if (!cy_q[CW-1]) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        z_q  <= z_q + $signed(Z_W'(atan_val));
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        z_q  <= z_q - $signed(Z_W'(atan_val));
      end
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // clamp, round to 1/64 degree and fold into the quadrant
  logic [20:0]       z_clamp;
  logic [21:0]       z_round;
  logic [HEAD_W-1:0] ang, h_quad, h_fin;

  always_comb begin
    if (z_q[Z_W-1]) begin
      z_clamp = '0;
    end else if (z_q > $signed(Z_W'(Z_MAX))) begin
      z_clamp = 21'(Z_MAX);
    end else begin
      z_clamp = z_q[20:0];
    end
    z_round = {1'b0, z_clamp} + 22'd128;
    ang     = HEAD_W'(z_round[21:8]);
    case ({neg_x_q, neg_y_q})
      2'b00:   h_quad = ang;
      2'b10:   h_quad = DEG_180 - ang;
      2'b11:   h_quad = DEG_180 + ang;
      default: h_quad = DEG_360 - ang;
    endcase
    if (h_quad >= DEG_360) begin
      h_quad = h_quad - DEG_360;
    end
    h_fin = cordic_q ? h_quad : h_q;
  end

  assign wr_en   = cmd_i.finish && !same_q;
  assign wr_data = {x_q, y_q, h_fin};

  hfd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (SLOT_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx_q),
    .wdata_i (wr_data),
    .re_i    (cmd_i.capture),
    .raddr_i (idx_in),
    .rdata_o (rd_data)
  );

  logic out_vld_q;
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        vld_q[idx_q] <= 1'b1;
        out_vld_q    <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.heading  <= h_fin;
      out_q.new_slot <= new_q;
      out_q.unmoved  <= same_q;
    end
  end

  assign sts_o.simple    = simple;
  assign sts_o.last_step = (cnt_q == CNT_W'(STEPS - 1));
  assign sts_o.out_free  = !out_vld_q || !out_stall_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/heading_from_displacement.sv =====
`timescale 1ns / 1ps

// Tracks the last position and heading of up to SLOT_COUNT objects and returns,
// for each position beat, the direction of motion in 1/64 degree from +x toward
// +y, in [0,360). A first sighting returns 0 with new_slot set, an unchanged
// position returns the stored heading with unmoved set, and axis-aligned moves
// give exact multiples of 90 degrees. After acceptance an item is evaluated, then
// goes straight to the output register when no CORDIC pass is needed and otherwise
// first through min(CORDIC_STEPS,24) steps of the CORDIC vectoring unit, which
// performs one micro-rotation per cycle. The next beat is accepted the cycle
// after a result is loaded into the output register, even while that result
// still waits on out_stall_i. No clearing pass is needed after reset.
module heading_from_displacement
  import hfd_pkg::*;
#(
  parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  hfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hfd_dp #(
    .SLOT_COUNT   (SLOT_COUNT),
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/heading_from_displacement_test.sv =====
`timescale 1ns / 1ps

module heading_from_displacement_test;
  import hfd_pkg::*;

  localparam int SLOTS        = 2 ** SLOT_W;
  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 500000;

  // atan(2^-i) in 1/16384 degree
  localparam longint ATAN_STEP [ATAN_LEN] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0, 0, 0
  };

  class heading_scoreboard;
    bit                        seen [SLOTS];
    logic signed [FIELD_W-1:0] pos_x [SLOTS];
    logic signed [FIELD_W-1:0] pos_y [SLOTS];
    logic [HEAD_W-1:0]         stored_heading [SLOTS];
    out_t                      expected_q [$];
    int                        errors;

    function new();
      errors = 0;
    endfunction

    // first-quadrant angle in 1/64 degree, both legs positive
    function int first_quadrant_angle(longint ax, longint ay);
      longint cx, cy, z, sx, sy;
      cx = ax <<< PRESCALE;
      cy = ay <<< PRESCALE;
      z  = 0;
      for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_LEN; i++) begin
        sx = cx >>> i;
        sy = cy >>> i;
        if (cy >= 0) begin
          cx = cx + sy;
          cy = cy - sx;
          z  = z + ATAN_STEP[i];
        end else begin
          cx = cx - sy;
          cy = cy + sx;
          z  = z - ATAN_STEP[i];
        end
      end
      if (z < 0) z = 0;
      if (z > Z_MAX) z = Z_MAX;
      return int'((z + 128) >>> 8);
    endfunction

    function out_t predict_heading(in_t d);
      out_t              r;
      logic [SLOT_W-1:0] s;
      int                a, h;
      longint            dx, dy;
      r = '0;
      s = d.slot;
      if (!seen[s]) begin
        seen[s]           = 1'b1;
        pos_x[s]          = d.x_coord;
        pos_y[s]          = d.y_coord;
        stored_heading[s] = DEG_0;
        r.new_slot        = 1'b1;
        return r;
      end
      if (d.x_coord == pos_x[s] && d.y_coord == pos_y[s]) begin
        r.heading = stored_heading[s];
        r.unmoved = 1'b1;
        return r;
      end
      dx = longint'(d.x_coord) - longint'(pos_x[s]);
      dy = longint'(d.y_coord) - longint'(pos_y[s]);
      if (dy == 0) begin
        h = (dx > 0) ? int'(DEG_0) : int'(DEG_180);
      end else if (dx == 0) begin
        h = (dy > 0) ? int'(DEG_90) : int'(DEG_270);
      end else begin
        a = first_quadrant_angle(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
        if (dx > 0 && dy > 0) h = a;
        else if (dx < 0 && dy > 0) h = int'(DEG_180) - a;
        else if (dx < 0) h = int'(DEG_180) + a;
        else h = int'(DEG_360) - a;
        if (h >= int'(DEG_360)) h = h - int'(DEG_360);
      end
      pos_x[s]          = d.x_coord;
      pos_y[s]          = d.y_coord;
      stored_heading[s] = h[HEAD_W-1:0];
      r.heading         = h[HEAD_W-1:0];
      return r;
    endfunction

    function void note_position(in_t d);
      expected_q = {expected_q, predict_heading(d)};
    endfunction

    function void check_heading(out_t r);
      out_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: heading %0d new_slot %0b unmoved %0b",
               r.heading, r.new_slot, r.unmoved);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.heading !== e.heading) begin
        $error("heading: expected %0d, actual %0d", e.heading, r.heading);
        errors++;
      end
      if (r.new_slot !== e.new_slot) begin
        $error("new_slot: expected %0b, actual %0b", e.new_slot, r.new_slot);
        errors++;
      end
      if (r.unmoved !== e.unmoved) begin
        $error("unmoved: expected %0b, actual %0b", e.unmoved, r.unmoved);
        errors++;
      end
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  heading_scoreboard sb = new();

  bit                        placed [SLOTS];
  logic signed [FIELD_W-1:0] placed_x [SLOTS];
  logic signed [FIELD_W-1:0] placed_y [SLOTS];
  int                        hot_slot [16];
  bit                        hold_request = 1'b0;
  bit                        calm = 1'b0;
  int                        cycles = 0;

  heading_from_displacement u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("heading_from_displacement: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_heading(out_data_o);
  end

  // receiver: random stalls, free runs, and one long hold-off on request
  initial begin
    int r;
    forever begin
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end else if (r < 60) begin
          out_stall_i <= 1'b0;
          repeat ($urandom_range(30, 120)) @(posedge clk_i);
        end else if (r < 92) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk_i);
        end
      end
    end
  end

  function automatic int beat_gap();
    int r;
    if (calm || hold_request) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_t position(int s, int x, int y);
    in_t d;
    d.slot    = s[SLOT_W-1:0];
    d.x_coord = x[FIELD_W-1:0];
    d.y_coord = y[FIELD_W-1:0];
    return d;
  endfunction

  // hold valid across back-to-back beats; only drop it for a real gap
  task automatic send_position(in_t d);
    int gap;
    gap = beat_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_position(d);
    placed[d.slot]   = 1'b1;
    placed_x[d.slot] = d.x_coord;
    placed_y[d.slot] = d.y_coord;
  endtask

  function automatic in_t pick_move();
    in_t                       d;
    logic [SLOT_W-1:0]         s;
    int                        kind;
    logic signed [FIELD_W-1:0] nx, ny;
    s = ($urandom_range(0, 99) < 8) ? SLOT_W'($urandom_range(0, SLOTS - 1))
                                    : SLOT_W'(hot_slot[4'($urandom_range(0, 15))]);
    kind = $urandom_range(0, 99);
    nx   = FIELD_W'($urandom());
    ny   = FIELD_W'($urandom());
    if (placed[s]) begin
      if (kind < 15) begin
        nx = placed_x[s];
        ny = placed_y[s];
      end else if (kind < 30) begin
        nx = placed_x[s];
        ny = placed_y[s];
        if ($urandom_range(0, 1)) nx = nx + FIELD_W'($urandom_range(1, 65535));
        else ny = ny + FIELD_W'($urandom_range(1, 65535));
      end else if (kind < 50) begin
        nx = placed_x[s] + FIELD_W'($urandom_range(0, 8)) - FIELD_W'(4);
        ny = placed_y[s] + FIELD_W'($urandom_range(0, 8)) - FIELD_W'(4);
      end
    end
    d.slot    = s;
    d.x_coord = nx;
    d.y_coord = ny;
    return d;
  endfunction

  initial begin
    foreach (hot_slot[i]) hot_slot[i] = $urandom_range(0, SLOTS - 1);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first sighting, unmoved, the four axis moves
    send_position(position(0, 0, 0));
    send_position(position(0, 0, 0));
    send_position(position(0, 256, 0));
    send_position(position(0, 256, 256));
    send_position(position(0, 0, 256));
    send_position(position(0, 0, 0));
    send_position(position(0, 0, 0));
    // extreme displacements in every quadrant
    send_position(position(0, -32768, -32768));
    send_position(position(0, 32767, 32767));
    send_position(position(0, -32768, 32767));
    send_position(position(0, -32767, -32768));
    send_position(position(0, -32768, -32767));
    send_position(position(0, -32767, -32768));
    send_position(position(255, 32767, -32768));
    send_position(position(255, -32768, 32767));
    send_position(position(255, 32767, 32767));
    send_position(position(255, 32766, -32768));
    // tiny angle just below +x rounds to a full turn and wraps
    send_position(position(2, -32768, 0));
    send_position(position(2, 32767, -1));
    send_position(position(2, -32768, 1));
    send_position(position(2, -32767, -32768));
    send_position(position(170, 21845, -21846));
    send_position(position(85, -21846, 21845));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 100 && n < 160);
      if (n == 250) hold_request = 1'b1;
      send_position(pick_move());
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("heading_from_displacement: match");
    end else begin
      $display("heading_from_displacement: mismatch");
    end
    $finish;
  end

endmodule
